// ===== rtl/rbd_pkg.sv =====
// Shared types, constants and channel arithmetic for the 2x2 RGBA box downsampler.
// No dependencies; imported by rbd_front, rbd_back, the top level and rbd_checker.
package rbd_pkg;

	localparam int PIX_W     = 32;
	localparam int CH_W      = 8;
	localparam int CH_N      = 4;
	localparam int CSUM_W    = 9;
	localparam int SUM_W     = CH_N * CSUM_W;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RST    = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// Stage-one control and payload between front end and output stage
	typedef struct packed {
		logic             vld;
		logic             wr;
		logic             last;
		logic [SUM_W-1:0] sum;
	} stage_t;

	// Per-channel sums of two pixels, nine bits per channel
	function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = '0;
		for (int c = 0; c < CH_N; c++) begin
			s[c*CSUM_W +: CSUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
		end
		return s;
	endfunction

	// Truncated mean of four: add the two pair sums, drop two bits
	function automatic logic [PIX_W-1:0] average_four(input logic [SUM_W-1:0] t,
			input logic [SUM_W-1:0] b);
		logic [PIX_W-1:0]  px;
		logic [CSUM_W:0]   tot;
		px  = '0;
		tot = '0;
		for (int c = 0; c < CH_N; c++) begin
			tot = {1'b0, t[c*CSUM_W +: CSUM_W]} + {1'b0, b[c*CSUM_W +: CSUM_W]};
			px[c*CH_W +: CH_W] = tot[CSUM_W:2];
		end
		return px;
	endfunction

endpackage

// ===== rtl/rbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rbd_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rbd_front.sv =====
// Front end: configuration registers, column/row counters, held pixel and pair sums.
// Issues line-buffer reads and writes; depends on rbd_pkg.
module rbd_front
	import rbd_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	localparam int LINE_DEPTH = MAX_WIDTH / 2,
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_vld,
	input  logic [PIX_W-1:0]     in_pix,
	input  logic                 adv,
	output stage_t               st_s1,
	output logic [IDX_W-1:0]     idx_s1,
	output logic                 rd_en,
	output logic [IDX_W-1:0]     rd_idx
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WSZ_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int HSZ_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

	logic [CFG_W-1:0] row_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] held_q;

	logic [WSZ_W-1:0] w_cfg, w_eff, w_even, col_x;
	logic [HSZ_W-1:0] h_cfg, h_eff, h_even, row_x;
	logic             accept, row_end, frame_end, pair_ok, last;
	logic [COL_W-1:0] col_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= ROW_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_WIDTH:    row_width_q    <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp sizes into one to the maximum
	always_comb begin
		w_cfg = WSZ_W'(row_width_q);
		h_cfg = HSZ_W'(frame_height_q);
		if (w_cfg == '0) begin
			w_eff = WSZ_W'(1);
		end else if (w_cfg > WSZ_W'(MAX_WIDTH)) begin
			w_eff = WSZ_W'(MAX_WIDTH);
		end else begin
			w_eff = w_cfg;
		end
		if (h_cfg == '0) begin
			h_eff = HSZ_W'(1);
		end else if (h_cfg > HSZ_W'(MAX_HEIGHT)) begin
			h_eff = HSZ_W'(MAX_HEIGHT);
		end else begin
			h_eff = h_cfg;
		end
		w_even = {w_eff[WSZ_W-1:1], 1'b0};
		h_even = {h_eff[HSZ_W-1:1], 1'b0};
		col_x  = WSZ_W'(col_q);
		row_x  = HSZ_W'(row_q);
	end

	assign accept    = in_vld && adv;
	assign row_end   = col_x >= (w_eff - WSZ_W'(1));
	assign frame_end = row_end && (row_x >= (h_eff - HSZ_W'(1)));
	assign pair_ok   = col_q[0] && (col_x < w_even) && (row_x < h_even);
	assign last      = (col_x == w_even - WSZ_W'(1)) && (row_x == h_even - HSZ_W'(1));
	assign col_half  = col_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				held_q <= in_pix;
			end
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= ROW_W'(row_q + 1'b1);
			end else begin
				col_q <= COL_W'(col_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1  <= '0;
			idx_s1 <= '0;
		end else if (adv) begin
			st_s1.vld  <= accept && pair_ok;
			st_s1.wr   <= !row_q[0];
			st_s1.last <= last;
			st_s1.sum  <= pair_sum(held_q, in_pix);
			idx_s1     <= col_half[IDX_W-1:0];
		end
	end

	// Odd row reads the top pair back; the even-row write to the same entry
	// always lands at least a row start earlier, so no forwarding is needed
	assign rd_en  = accept && pair_ok && row_q[0];
	assign rd_idx = col_half[IDX_W-1:0];

endmodule

// ===== rtl/rbd_back.sv =====
// Output stage: combines the stored top pair with the bottom pair, holds the result word.
// Depends on rbd_pkg.
module rbd_back
	import rbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  stage_t           st_s1,
	input  logic [SUM_W-1:0] top_sum,
	output logic             adv,
	output logic             out_vld,
	input  logic             out_rdy,
	output logic [PIX_W-1:0] out_pix,
	output logic             out_last
);

	logic emit;

	// Stage one moves unless it holds a result and the output word is stuck
	assign adv  = !st_s1.vld || st_s1.wr || !out_vld || out_rdy;
	assign emit = st_s1.vld && !st_s1.wr && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (emit) begin
			out_vld <= 1'b1;
		end else if (out_rdy) begin
			out_vld <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pix  <= average_four(top_sum, st_s1.sum);
			out_last <= st_s1.last;
		end
	end

endmodule

// ===== rtl/rgba_box_downsample_2x2_top.sv =====
// Channel     | Dir | Payload                           | Handshake
// s_axis      | in  | tdata[31:0] pixel_in              | tvalid/tready
// m_axis      | out | tdata[31:0] pixel_out, tlast      | tvalid/tready
// cfg         | in  | cfg_index, cfg_data[11:0]         | cfg_we, no wait
//
// One pixel accepted per clock while s_axis_tready is high; a result word
// passes stage one and then the output word register after the pixel that
// completes its 2x2 block. The line buffer is one RAM of MAX_WIDTH/2 pair
// sums, written on even rows and read on odd rows. Reset clears all
// registers but the output data; the RAM is not cleared. A stalled output
// word holds; one more result waits in stage one, then s_axis_tready drops.
// Top level of the 2x2 RGBA box downsampler; depends on rbd_pkg, rbd_ram,
// rbd_front and rbd_back.
module rgba_box_downsample_2x2_top
	import rbd_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [PIX_W-1:0]     s_axis_tdata,   // pixel_in[31:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [PIX_W-1:0]     m_axis_tdata,   // pixel_out[31:0]
	output logic                 m_axis_tlast,   // frame_last
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	stage_t           st_s1;
	logic [IDX_W-1:0] idx_s1, rd_idx;
	logic             rd_en, adv;
	logic [SUM_W-1:0] top_sum;

	assign s_axis_tready = adv;

	rbd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_vld    (s_axis_tvalid),
		.in_pix    (s_axis_tdata),
		.adv       (adv),
		.st_s1     (st_s1),
		.idx_s1    (idx_s1),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx)
	);

	rbd_ram #(
		.WIDTH (SUM_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (st_s1.vld && st_s1.wr),
		.waddr (idx_s1),
		.wdata (st_s1.sum),
		.re    (rd_en),
		.raddr (rd_idx),
		.rdata (top_sum)
	);

	rbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.st_s1    (st_s1),
		.top_sum  (top_sum),
		.adv      (adv),
		.out_vld  (m_axis_tvalid),
		.out_rdy  (m_axis_tready),
		.out_pix  (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== rtl/rbd_checker.sv =====
// Port-level checks for the 2x2 RGBA box downsampler, bound to the top level.
// Depends on rbd_pkg.
module rbd_checker
	import rbd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [PIX_W-1:0] m_axis_tdata,
	input logic             m_axis_tlast
);

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed under stall");

	// Input back-pressure only arises from a waiting output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// A fresh output word follows an accepted pixel by way of stage one and the output register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("output word without a source pixel");

	// Free-flowing output never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

endmodule

bind rgba_box_downsample_2x2_top rbd_checker u_rbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
